// ===== rtl/core/rgb_led_pattern_engine_macros.svh =====
// ----------------------------------------------------------------------------
// RGB LED pattern engine assertion macros
// Concurrent check helpers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_PATTERN_ENGINE_MACROS_SVH
`define RGB_LED_PATTERN_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RLPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlpe check failed");
// next-cycle implication
`define RLPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlpe check failed");
`else
`define RLPE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RLPE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/rlpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types, codes and constants of the RGB LED pattern engine.
// ----------------------------------------------------------------------------
package rlpe_pkg;

    // request opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // pattern kinds
    localparam logic [1:0] KIND_STATIC = 2'd0;
    localparam logic [1:0] KIND_FADE   = 2'd1;
    localparam logic [1:0] KIND_BLINK  = 2'd2;
    localparam logic [1:0] KIND_CROSS  = 2'd3;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLINKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLAGS  = 3'd7;

    // option flag bits
    localparam int FLAG_REPEAT  = 0;
    localparam int FLAG_REVERSE = 1;
    localparam int FLAG_INVERT  = 2;

    localparam logic [6:0]  PERCENT     = 7'd100;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;
    localparam logic [7:0]  BLINK_MAX   = 8'd255;
    // x / 100 == (x * 5243) >> 19 for x up to 25500
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam int          DIV_STEPS   = 8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_DIV,
        S_SCL1,
        S_SCL2,
        S_STORE,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_OFF,
        ACT_COLOR,
        ACT_BLEND
    } t_act;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_init;
        logic div_step;
        logic scl_a;
        logic scl_b;
        logic store;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_act act_now;
        t_act act;
        logic last_chan;
        logic div_last;
        logic out_free;
    } t_sts;

    // pick one 8-bit channel of a packed colour, index 0 is blue
    function automatic logic [7:0] chan_of(input logic [23:0] c, input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0:    v = c[7:0];
            2'd1:    v = c[15:8];
            default: v = c[23:16];
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/rgb_led_pattern_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_pattern_engine
// Timed RGB LED pattern engine: start, stop and tick requests drive three
// PWM duty values through static, fade, blink and crossfade patterns.
// ----------------------------------------------------------------------------
// Requests that write no colour or the off colour go straight to the output
// register; a solid colour takes 3 scale passes, one per channel, and a blend
// adds multiply, sum and 8 divider steps before each pass, on the shared divider.
// One request at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) clears pattern state and duty, brightness 100.
module rgb_led_pattern_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [31:0]                    i_now_ms,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_red_duty,
    output logic [7:0]                     o_green_duty,
    output logic [7:0]                     o_blue_duty,
    output logic                           o_duty_written,
    output logic                           o_pattern_active,
    input  logic                           i_cfg_we,
    input  logic [rlpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rlpe_pkg::CFG_W-1:0]     i_cfg_wdata
);

    rlpe_pkg::t_cmd cmd;
    rlpe_pkg::t_sts sts;

    rlpe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rlpe_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_opcode         (i_opcode),
        .i_now_ms         (i_now_ms),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_stall          (i_stall),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .o_red_duty       (o_red_duty),
        .o_green_duty     (o_green_duty),
        .o_blue_duty      (o_blue_duty),
        .o_duty_written   (o_duty_written),
        .o_pattern_active (o_pattern_active)
    );

endmodule

// ===== rtl/core/rlpe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_ctrl
// Sequencer: accept a request, run blend division (blends only) and scaling per
// channel when a colour is written, then hand the result to the output register.
// ----------------------------------------------------------------------------
`include "rgb_led_pattern_engine_macros.svh"
module rlpe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rlpe_pkg::t_sts i_sts,
    output rlpe_pkg::t_cmd o_cmd
);

    rlpe_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlpe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlpe_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (i_sts.act_now)
                        rlpe_pkg::ACT_BLEND: n_state = rlpe_pkg::S_MUL;
                        rlpe_pkg::ACT_COLOR: n_state = rlpe_pkg::S_SCL1;
                        default:             n_state = rlpe_pkg::S_OUT;
                    endcase
                end
            end
            rlpe_pkg::S_MUL:  n_state = rlpe_pkg::S_SUM;
            rlpe_pkg::S_SUM:  n_state = rlpe_pkg::S_DIV;
            rlpe_pkg::S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = rlpe_pkg::S_SCL1;
                end
            end
            rlpe_pkg::S_SCL1: n_state = rlpe_pkg::S_SCL2;
            rlpe_pkg::S_SCL2: n_state = rlpe_pkg::S_STORE;
            rlpe_pkg::S_STORE: begin
                if (i_sts.last_chan) begin
                    n_state = rlpe_pkg::S_OUT;
                end else if (i_sts.act == rlpe_pkg::ACT_BLEND) begin
                    n_state = rlpe_pkg::S_MUL;
                end else begin
                    n_state = rlpe_pkg::S_SCL1;
                end
            end
            rlpe_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = rlpe_pkg::S_IDLE;
                end
            end
            default: n_state = rlpe_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_stall        = (r_state != rlpe_pkg::S_IDLE);
        o_cmd.accept   = (r_state == rlpe_pkg::S_IDLE) && i_valid;
        o_cmd.mul      = (r_state == rlpe_pkg::S_MUL);
        o_cmd.div_init = (r_state == rlpe_pkg::S_SUM);
        o_cmd.div_step = (r_state == rlpe_pkg::S_DIV);
        o_cmd.scl_a    = (r_state == rlpe_pkg::S_SCL1);
        o_cmd.scl_b    = (r_state == rlpe_pkg::S_SCL2);
        o_cmd.store    = (r_state == rlpe_pkg::S_STORE);
        o_cmd.load_out = (r_state == rlpe_pkg::S_OUT) && i_sts.out_free;
    end

    `RLPE_ASSERT_NEXT(a_div_exit, i_clk, i_rst_n, (r_state == rlpe_pkg::S_DIV) && i_sts.div_last, r_state == rlpe_pkg::S_SCL1)
    `RLPE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, o_cmd.accept, r_state != rlpe_pkg::S_IDLE)
    `RLPE_ASSERT_NEXT(a_last_store, i_clk, i_rst_n, o_cmd.store && i_sts.last_chan, r_state == rlpe_pkg::S_OUT)
    `RLPE_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, o_cmd.load_out, r_state == rlpe_pkg::S_IDLE)

endmodule

// ===== rtl/core/rlpe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpe_dp
// Registers, pattern decision, serial blend divider, brightness scaling and
// output register of the RGB LED pattern engine.
// ----------------------------------------------------------------------------
module rlpe_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [1:0]                      i_opcode,
    input  logic [31:0]                     i_now_ms,
    input  logic                            i_cfg_we,
    input  logic [rlpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rlpe_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_stall,
    input  rlpe_pkg::t_cmd                  i_cmd,
    output rlpe_pkg::t_sts                  o_sts,
    output logic                            o_valid,
    output logic [7:0]                      o_red_duty,
    output logic [7:0]                      o_green_duty,
    output logic [7:0]                      o_blue_duty,
    output logic                            o_duty_written,
    output logic                            o_pattern_active
);

    // configuration
    logic [1:0]  r_kind;
    logic [23:0] r_color1, r_color2;
    logic [31:0] r_time1, r_time2;
    logic [7:0]  r_blink_lim;
    logic [6:0]  r_bright;
    logic [2:0]  r_flags;

    // pattern state
    logic        r_running, n_running;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_start, n_start;
    logic [31:0] r_last, n_last;
    logic [7:0]  r_blinks, n_blinks;
    logic [23:0] r_duty;
    logic        r_wrote;

    // work registers
    rlpe_pkg::t_act r_act, n_act;
    logic [23:0] r_from, n_from;
    logic [23:0] r_to, n_to;
    logic [31:0] r_e, n_e;
    logic [1:0]  r_chan;
    logic [39:0] r_prod_a, r_prod_b;
    logic [31:0] r_rem;
    logic [7:0]  r_lo;
    logic [7:0]  r_quo;
    logic [2:0]  r_cnt;
    logic [14:0] r_scl_a;
    logic [27:0] r_scl_b;

    logic [31:0] e_start, e_last;
    logic [7:0]  blink_next;
    logic [40:0] num;
    logic [32:0] trial;
    logic        fits;
    logic [6:0]  bright;
    logic [7:0]  v_in, v_out;
    logic [23:0] off_color;

    assign e_start    = i_now_ms - r_start;
    assign e_last     = i_now_ms - r_last;
    assign blink_next = (r_blinks < rlpe_pkg::BLINK_MAX) ? r_blinks + 8'd1 : r_blinks;
    assign off_color  = r_flags[rlpe_pkg::FLAG_INVERT] ? 24'hFFFFFF : 24'h000000;

    // decide the state update and duty action of one request
    always_comb begin
        n_running = r_running;
        n_phase   = r_phase;
        n_start   = r_start;
        n_last    = r_last;
        n_blinks  = r_blinks;
        n_act     = rlpe_pkg::ACT_NONE;
        n_from    = r_color1;
        n_to      = r_color2;
        n_e       = e_last;
        unique case (i_opcode)
            rlpe_pkg::OP_START: begin
                n_running = 1'b1;
                n_phase   = 2'd0;
                n_blinks  = 8'd0;
                n_start   = i_now_ms;
                n_last    = i_now_ms;
            end
            rlpe_pkg::OP_STOP: begin
                n_act     = rlpe_pkg::ACT_OFF;
                n_running = 1'b0;
            end
            rlpe_pkg::OP_TICK: begin
                if (r_running) begin
                    unique case (r_kind)
                        rlpe_pkg::KIND_STATIC: begin
                            if (r_phase == 2'd0) begin
                                n_act   = rlpe_pkg::ACT_COLOR;
                                n_to    = r_color1;
                                n_phase = 2'd1;
                            end
                            if (r_phase[1] == 1'b0 && e_start >= r_time1) begin
                                if (r_flags[rlpe_pkg::FLAG_REPEAT]) begin
                                    n_start = i_now_ms;
                                    n_phase = 2'd0;
                                end else begin
                                    n_act     = rlpe_pkg::ACT_OFF;
                                    n_running = 1'b0;
                                end
                            end
                        end
                        rlpe_pkg::KIND_FADE: begin
                            if (r_phase == 2'd0) begin
                                if (e_start < r_time1) begin
                                    n_act = rlpe_pkg::ACT_BLEND;
                                    n_e   = e_start;
                                end else begin
                                    n_act   = rlpe_pkg::ACT_COLOR;
                                    n_phase = 2'd1;
                                    n_last  = i_now_ms;
                                end
                            end else if (r_phase == 2'd1 && e_last >= r_time2) begin
                                if (r_flags[rlpe_pkg::FLAG_REPEAT]) begin
                                    n_start = i_now_ms;
                                    n_phase = 2'd0;
                                end else begin
                                    n_act     = rlpe_pkg::ACT_OFF;
                                    n_running = 1'b0;
                                end
                            end
                        end
                        rlpe_pkg::KIND_BLINK: begin
                            if (r_phase == 2'd0) begin
                                n_act = rlpe_pkg::ACT_COLOR;
                                n_to  = r_color1;
                                if (e_last >= r_time1) begin
                                    n_phase = 2'd1;
                                    n_last  = i_now_ms;
                                end
                            end else if (r_phase == 2'd1) begin
                                n_act = rlpe_pkg::ACT_OFF;
                                if (e_last >= r_time2) begin
                                    n_blinks = blink_next;
                                    if (r_blink_lim != 8'd0 && blink_next >= r_blink_lim) begin
                                        if (r_flags[rlpe_pkg::FLAG_REPEAT]) begin
                                            n_blinks = 8'd0;
                                            n_phase  = 2'd0;
                                            n_last   = i_now_ms;
                                        end else begin
                                            n_running = 1'b0;
                                        end
                                    end else begin
                                        n_phase = 2'd0;
                                        n_last  = i_now_ms;
                                    end
                                end
                            end
                        end
                        default: begin
                            // crossfade: even phases blend, odd phases hold
                            if (r_phase[0] == 1'b0) begin
                                n_from = r_phase[1] ? r_color2 : r_color1;
                                n_to   = r_phase[1] ? r_color1 : r_color2;
                                if (e_last < r_time1) begin
                                    n_act = rlpe_pkg::ACT_BLEND;
                                end else begin
                                    n_act   = rlpe_pkg::ACT_COLOR;
                                    n_phase = r_phase + 2'd1;
                                    n_last  = i_now_ms;
                                end
                            end else if (e_last >= r_time2) begin
                                if (r_phase == 2'd1 && r_flags[rlpe_pkg::FLAG_REVERSE]) begin
                                    n_phase = 2'd2;
                                    n_last  = i_now_ms;
                                end else if (r_flags[rlpe_pkg::FLAG_REPEAT]) begin
                                    n_phase = 2'd0;
                                    n_last  = i_now_ms;
                                end else begin
                                    n_act     = rlpe_pkg::ACT_OFF;
                                    n_running = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= 2'd0;
            r_color1    <= 24'd0;
            r_color2    <= 24'd0;
            r_time1     <= 32'd0;
            r_time2     <= 32'd0;
            r_blink_lim <= 8'd0;
            r_bright    <= rlpe_pkg::PERCENT;
            r_flags     <= 3'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rlpe_pkg::REG_KIND:   r_kind      <= i_cfg_wdata[1:0];
                rlpe_pkg::REG_COLOR1: r_color1    <= i_cfg_wdata[23:0];
                rlpe_pkg::REG_COLOR2: r_color2    <= i_cfg_wdata[23:0];
                rlpe_pkg::REG_TIME1:  r_time1     <= i_cfg_wdata;
                rlpe_pkg::REG_TIME2:  r_time2     <= i_cfg_wdata;
                rlpe_pkg::REG_BLINKS: r_blink_lim <= i_cfg_wdata[7:0];
                rlpe_pkg::REG_BRIGHT: r_bright    <= i_cfg_wdata[6:0];
                default:              r_flags     <= i_cfg_wdata[2:0];
            endcase
        end
    end

    // pattern state, duty hold and write flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_phase   <= 2'd0;
            r_start   <= 32'd0;
            r_last    <= 32'd0;
            r_blinks  <= 8'd0;
            r_duty    <= 24'd0;
            r_wrote   <= 1'b0;
            r_act     <= rlpe_pkg::ACT_NONE;
        end else if (i_cmd.accept) begin
            r_running <= n_running;
            r_phase   <= n_phase;
            r_start   <= n_start;
            r_last    <= n_last;
            r_blinks  <= n_blinks;
            r_act     <= n_act;
            r_wrote   <= (n_act != rlpe_pkg::ACT_NONE);
            if (n_act == rlpe_pkg::ACT_OFF) begin
                r_duty <= off_color;
            end
        end else if (i_cmd.store) begin
            unique case (r_chan)
                2'd0:    r_duty[7:0]   <= v_out;
                2'd1:    r_duty[15:8]  <= v_out;
                default: r_duty[23:16] <= v_out;
            endcase
        end
    end

    // channel counter and operand capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= 2'd0;
        end else if (i_cmd.accept) begin
            r_chan <= 2'd0;
        end else if (i_cmd.store) begin
            r_chan <= r_chan + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_from <= n_from;
            r_to   <= n_to;
            r_e    <= n_e;
        end
    end

    // blend products, then numerator split into remainder and low bits
    assign num = {1'b0, r_prod_a} + {1'b0, r_prod_b};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_a <= rlpe_pkg::chan_of(r_from, r_chan) * (r_time1 - r_e);
            r_prod_b <= rlpe_pkg::chan_of(r_to, r_chan) * r_e;
        end
    end

    // restoring divider, quotient below 256 so eight steps
    assign trial = {r_rem, r_lo[7]};
    assign fits  = (trial >= {1'b0, r_time1});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= num[39:8];
            r_lo  <= num[7:0];
            r_quo <= 8'd0;
            r_cnt <= 3'd0;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? 32'(trial - {1'b0, r_time1}) : trial[31:0];
            r_lo  <= {r_lo[6:0], 1'b0};
            r_quo <= {r_quo[6:0], fits};
            r_cnt <= r_cnt + 3'd1;
        end
    end

    // brightness scale: v * pct, then divide by 100 through a reciprocal
    assign bright = (r_bright > rlpe_pkg::PERCENT) ? rlpe_pkg::PERCENT : r_bright;
    assign v_in   = (r_act == rlpe_pkg::ACT_BLEND) ? r_quo : rlpe_pkg::chan_of(r_to, r_chan);
    assign v_out  = r_flags[rlpe_pkg::FLAG_INVERT]
                  ? rlpe_pkg::FULL_SCALE - r_scl_b[rlpe_pkg::RECIP_SHIFT +: 8]
                  : r_scl_b[rlpe_pkg::RECIP_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (i_cmd.scl_a) begin
            r_scl_a <= v_in * bright;
        end
        if (i_cmd.scl_b) begin
            r_scl_b <= r_scl_a * rlpe_pkg::RECIP_100;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_red_duty       <= r_duty[23:16];
            o_green_duty     <= r_duty[15:8];
            o_blue_duty      <= r_duty[7:0];
            o_duty_written   <= r_wrote;
            o_pattern_active <= r_running;
        end
    end

    // status
    always_comb begin
        o_sts           = '0;
        o_sts.act_now   = n_act;
        o_sts.act       = r_act;
        o_sts.last_chan = (r_chan == 2'd2);
        o_sts.div_last  = (r_cnt == 3'(rlpe_pkg::DIV_STEPS - 1));
        o_sts.out_free  = !o_valid || !i_stall;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the RGB LED pattern engine. It drives start, stop and tick
// requests with timestamps, predicts each duty result from its own copy of
// the pattern state and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;

    // opcode that the engine ignores
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [23:0] color1;
        logic [23:0] color2;
        logic [31:0] time1;
        logic [31:0] time2;
        logic [7:0]  blinks;
        logic [6:0]  bright;
        logic [2:0]  flags;
    } t_pattern_cfg;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       written;
        logic       active;
    } t_duty_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = rlpe_pkg::OP_TICK;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_red_duty, o_green_duty, o_blue_duty;
    logic        o_duty_written, o_pattern_active;
    logic        i_cfg_we = 1'b0;
    logic [rlpe_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [rlpe_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    rgb_led_pattern_engine dut (.*);

    // predictor copy of registers and pattern state
    t_pattern_cfg cfg_now;
    logic        run_on;
    logic [1:0]  run_phase;
    logic [31:0] start_ms, last_ms;
    logic [7:0]  blinks_seen;
    logic [23:0] duty_now;
    logic        duty_wrote;

    t_duty_result duty_queue[$];
    int errors = 0;
    int checked = 0;
    int requests = 0;
    bit steady = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // scale by brightness, then invert for common anode
    function automatic logic [23:0] scaled_color(input logic [23:0] rgb);
        logic [23:0] res;
        int br, v;
        br = (cfg_now.bright > rlpe_pkg::PERCENT) ? rlpe_pkg::PERCENT : cfg_now.bright;
        for (int k = 0; k < 3; k++) begin
            v = rgb[k*8 +: 8] * br / 100;
            if (cfg_now.flags[rlpe_pkg::FLAG_INVERT]) v = rlpe_pkg::FULL_SCALE - v;
            res[k*8 +: 8] = v[7:0];
        end
        return res;
    endfunction

    function automatic logic [23:0] blend_color(input logic [23:0] a, input logic [23:0] b,
                                                input logic [31:0] e, input logic [31:0] t);
        logic [23:0] res;
        logic [63:0] num;
        for (int k = 0; k < 3; k++) begin
            num = 64'(a[k*8 +: 8]) * 64'(t - e) + 64'(b[k*8 +: 8]) * 64'(e);
            res[k*8 +: 8] = 8'(num / 64'(t));
        end
        return res;
    endfunction

    task automatic put_color(input logic [23:0] rgb);
        duty_now = scaled_color(rgb);
        duty_wrote = 1'b1;
    endtask

    task automatic put_off();
        duty_now = cfg_now.flags[rlpe_pkg::FLAG_INVERT] ? 24'hFFFFFF : 24'h0;
        duty_wrote = 1'b1;
    endtask

    task automatic halt_pattern();
        put_off();
        run_on = 1'b0;
    endtask

    // advance the pattern for one request and record the expected result
    task automatic predict_duty(input logic [1:0] op, input logic [31:0] now);
        logic [31:0] e;
        t_duty_result r;
        duty_wrote = 1'b0;
        if (op == rlpe_pkg::OP_START) begin
            run_on = 1'b1; run_phase = 2'd0; blinks_seen = 8'd0;
            start_ms = now; last_ms = now;
        end else if (op == rlpe_pkg::OP_STOP) begin
            halt_pattern();
        end else if (op == rlpe_pkg::OP_TICK && run_on) begin
            case (cfg_now.kind)
                rlpe_pkg::KIND_STATIC: begin
                    e = now - start_ms;
                    if (run_phase == 2'd0) begin
                        put_color(cfg_now.color1);
                        run_phase = 2'd1;
                    end
                    if (run_phase == 2'd1 && e >= cfg_now.time1) begin
                        if (cfg_now.flags[rlpe_pkg::FLAG_REPEAT]) begin
                            start_ms = now; run_phase = 2'd0;
                        end else halt_pattern();
                    end
                end
                rlpe_pkg::KIND_FADE: begin
                    if (run_phase == 2'd0) begin
                        e = now - start_ms;
                        if (e < cfg_now.time1)
                            put_color(blend_color(cfg_now.color1, cfg_now.color2, e,
                                                  cfg_now.time1));
                        else begin
                            put_color(cfg_now.color2);
                            run_phase = 2'd1; last_ms = now;
                        end
                    end else if (run_phase == 2'd1 && now - last_ms >= cfg_now.time2) begin
                        if (cfg_now.flags[rlpe_pkg::FLAG_REPEAT]) begin
                            start_ms = now; run_phase = 2'd0;
                        end else halt_pattern();
                    end
                end
                rlpe_pkg::KIND_BLINK: begin
                    e = now - last_ms;
                    if (run_phase == 2'd0) begin
                        put_color(cfg_now.color1);
                        if (e >= cfg_now.time1) begin
                            run_phase = 2'd1; last_ms = now;
                        end
                    end else if (run_phase == 2'd1) begin
                        put_off();
                        if (e >= cfg_now.time2) begin
                            if (blinks_seen < rlpe_pkg::BLINK_MAX) blinks_seen++;
                            if (cfg_now.blinks > 0 && blinks_seen >= cfg_now.blinks) begin
                                if (cfg_now.flags[rlpe_pkg::FLAG_REPEAT]) begin
                                    blinks_seen = 8'd0; run_phase = 2'd0; last_ms = now;
                                end else halt_pattern();
                            end else begin
                                run_phase = 2'd0; last_ms = now;
                            end
                        end
                    end
                end
                default: begin
                    e = now - last_ms;
                    if (run_phase == 2'd0 || run_phase == 2'd2) begin
                        if (e < cfg_now.time1)
                            put_color(run_phase == 2'd0
                                ? blend_color(cfg_now.color1, cfg_now.color2, e, cfg_now.time1)
                                : blend_color(cfg_now.color2, cfg_now.color1, e, cfg_now.time1));
                        else begin
                            put_color(run_phase == 2'd0 ? cfg_now.color2 : cfg_now.color1);
                            run_phase = run_phase + 2'd1; last_ms = now;
                        end
                    end else if (e >= cfg_now.time2) begin
                        if (run_phase == 2'd1 && cfg_now.flags[rlpe_pkg::FLAG_REVERSE]) begin
                            run_phase = 2'd2; last_ms = now;
                        end else if (cfg_now.flags[rlpe_pkg::FLAG_REPEAT]) begin
                            run_phase = 2'd0; last_ms = now;
                        end else halt_pattern();
                    end
                end
            endcase
        end
        r.red = duty_now[23:16];
        r.green = duty_now[15:8];
        r.blue = duty_now[7:0];
        r.written = duty_wrote;
        r.active = run_on;
        duty_queue.push_back(r);
    endtask

    // send one request, at times with a random gap before it
    task automatic send_request(input logic [1:0] op, input logic [31:0] now);
        if (!steady && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
        predict_duty(op, now);
        requests++;
    endtask

    // drain, then write every register
    task automatic load_pattern(input t_pattern_cfg c);
        i_valid <= 1'b0;
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= k[rlpe_pkg::CFG_IDX_W-1:0];
            case (k[rlpe_pkg::CFG_IDX_W-1:0])
                rlpe_pkg::REG_KIND:   i_cfg_wdata <= 32'(c.kind);
                rlpe_pkg::REG_COLOR1: i_cfg_wdata <= 32'(c.color1);
                rlpe_pkg::REG_COLOR2: i_cfg_wdata <= 32'(c.color2);
                rlpe_pkg::REG_TIME1:  i_cfg_wdata <= c.time1;
                rlpe_pkg::REG_TIME2:  i_cfg_wdata <= c.time2;
                rlpe_pkg::REG_BLINKS: i_cfg_wdata <= 32'(c.blinks);
                rlpe_pkg::REG_BRIGHT: i_cfg_wdata <= 32'(c.bright);
                default:              i_cfg_wdata <= 32'(c.flags);
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    // stall the result side at random
    always @(posedge i_clk) begin
        i_stall <= steady ? 1'b0 : ($urandom_range(99) < 25);
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_duty_result x;
        if (i_rst_n && o_valid && !i_stall) begin
            if (duty_queue.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                x = duty_queue.pop_front();
                checked++;
                if (o_red_duty !== x.red) begin
                    $error("red_duty exp %0d got %0d", x.red, o_red_duty); errors++;
                end
                if (o_green_duty !== x.green) begin
                    $error("green_duty exp %0d got %0d", x.green, o_green_duty); errors++;
                end
                if (o_blue_duty !== x.blue) begin
                    $error("blue_duty exp %0d got %0d", x.blue, o_blue_duty); errors++;
                end
                if (o_duty_written !== x.written) begin
                    $error("duty_written exp %0d got %0d", x.written, o_duty_written);
                    errors++;
                end
                if (o_pattern_active !== x.active) begin
                    $error("pattern_active exp %0d got %0d", x.active, o_pattern_active);
                    errors++;
                end
            end
        end
    end

    // idle engine: tick, ignored opcode, stop with reset brightness, then stop inverted
    task automatic test_idle_requests();
        t_pattern_cfg c;
        send_request(rlpe_pkg::OP_TICK, 32'hFFFFFFFF);
        send_request(OP_IGNORED, 32'h0);
        send_request(rlpe_pkg::OP_STOP, 32'h5A5A5A5A);
        c = '{rlpe_pkg::KIND_STATIC, 24'hFFFFFF, 24'h0, 32'd0, 32'd0, 8'd0, 7'd127,
              3'b100};
        load_pattern(c);
        send_request(rlpe_pkg::OP_STOP, 32'hA5A5A5A5);
    endtask

    // static colour across the timestamp wrap, then repeat with zero time
    task automatic test_static_hold();
        t_pattern_cfg c;
        c = '{rlpe_pkg::KIND_STATIC, 24'hFF8001, 24'h0, 32'd2, 32'd0, 8'd0, 7'd100,
              3'b000};
        load_pattern(c);
        send_request(rlpe_pkg::OP_START, 32'hFFFFFFFE);
        send_request(rlpe_pkg::OP_TICK, 32'hFFFFFFFF);
        send_request(rlpe_pkg::OP_TICK, 32'h0);
        c = '{rlpe_pkg::KIND_STATIC, 24'h123456, 24'h0, 32'd0, 32'd0, 8'd0, 7'd0, 3'b001};
        load_pattern(c);
        send_request(rlpe_pkg::OP_START, 32'd7);
        send_request(rlpe_pkg::OP_TICK, 32'd7);
        send_request(OP_IGNORED, 32'd8);
    endtask

    // fade with full-range colours and huge durations
    task automatic test_fade();
        t_pattern_cfg c;
        c = '{rlpe_pkg::KIND_FADE, 24'hFFFFFF, 24'h000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
              8'd0, 7'd50, 3'b101};
        load_pattern(c);
        send_request(rlpe_pkg::OP_START, 32'd100);
        send_request(rlpe_pkg::OP_TICK, 32'h80000000);
        send_request(rlpe_pkg::OP_TICK, 32'd99);
        send_request(rlpe_pkg::OP_STOP, 32'd1);
    endtask

    // blink with limit, crossfade with reverse, and kind rewrite
    task automatic test_blink_and_cross();
        t_pattern_cfg c;
        c = '{rlpe_pkg::KIND_BLINK, 24'h00FF00, 24'h0, 32'd0, 32'd0, 8'd255, 7'd99,
              3'b000};
        load_pattern(c);
        send_request(rlpe_pkg::OP_START, 32'd0);
        send_request(rlpe_pkg::OP_TICK, 32'd0);
        send_request(rlpe_pkg::OP_TICK, 32'd0);
        c = '{rlpe_pkg::KIND_CROSS, 24'hFF0000, 24'h0000FF, 32'd1, 32'd0, 8'd0, 7'd100,
              3'b010};
        load_pattern(c);
        send_request(rlpe_pkg::OP_START, 32'd10);
        send_request(rlpe_pkg::OP_TICK, 32'd11);
        send_request(rlpe_pkg::OP_TICK, 32'd11);
        // phase two is now set; a static kind leaves it stuck
        c.kind = rlpe_pkg::KIND_STATIC;
        load_pattern(c);
        send_request(rlpe_pkg::OP_TICK, 32'd12);
        send_request(rlpe_pkg::OP_STOP, 32'd13);
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFFFFFF;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // random patterns: configure, start, a run of ticks, with noise
    task automatic test_random_patterns();
        t_pattern_cfg c;
        logic [31:0] now;
        for (int s = 0; s < 45; s++) begin
            steady = (s >= 12 && s < 18);
            c.kind = 2'($urandom_range(3));
            c.color1 = 24'($urandom());
            c.color2 = 24'($urandom());
            c.time1 = pick_time();
            c.time2 = pick_time();
            c.blinks = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
            c.bright = ($urandom_range(3) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 100));
            c.flags = 3'($urandom_range(7));
            load_pattern(c);
            now = $urandom();
            if ($urandom_range(3) == 0) send_request(rlpe_pkg::OP_TICK, now);
            send_request(rlpe_pkg::OP_START, now);
            repeat ($urandom_range(5, 12)) begin
                now = now + $urandom_range(0, 4);
                case ($urandom_range(19))
                    0: send_request(rlpe_pkg::OP_STOP, now);
                    1: send_request(OP_IGNORED, $urandom());
                    2: send_request(rlpe_pkg::OP_START, now);
                    default: send_request(rlpe_pkg::OP_TICK, now);
                endcase
            end
        end
        steady = 0;
    endtask

    initial begin
        cfg_now = '{rlpe_pkg::KIND_STATIC, 24'd0, 24'd0, 32'd0, 32'd0, 8'd0,
                    rlpe_pkg::PERCENT, 3'b000};
        run_on = 1'b0; run_phase = 2'd0; start_ms = 32'd0; last_ms = 32'd0;
        blinks_seen = 8'd0; duty_now = 24'd0; duty_wrote = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_requests();
        test_static_hold();
        test_fade();
        test_blink_and_cross();
        test_random_patterns();
        i_valid <= 1'b0;
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Ran %0d requests over all four pattern kinds, %0d results compared.",
                 requests, checked);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
